[hdl/wma_pkg.sv]
package wma_pkg;

  localparam int unsigned LEN_W = 7;

  typedef enum logic [0:0] {
    CFG_WINDOW_LENGTH = 1'b0,
    CFG_MEAN_MODE     = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } wma_state_e;

endpackage

[hdl/windowed_moving_average.sv]
// in mean mode each input transfer is followed by the one-entry-per-cycle window sum and a
// restoring divider of SAMPLE_BITS + 7 steps before the result is ready; with mean mode off the
// held mean is returned; a position past a shrunken window adds a divider pass for the new position
// one item at a time: input is refused until the last result has entered the output register,
// and that waits while the output register still holds a result not yet taken by the sink
// reset: clears control state, then a pass over every ring address zeroes the ring before input opens
module windowed_moving_average #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wma_pkg::cfg_reg_e                  cfg_index_i,
  input  logic [wma_pkg::LEN_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]      sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]      mean_value_o
);
  import wma_pkg::*;

  localparam int unsigned PW      = $clog2(MAX_WINDOW);
  localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
  localparam int unsigned LEN_CAP = (MAX_WINDOW < LEN_MAX) ? MAX_WINDOW : LEN_MAX;
  localparam int unsigned CMP_W   = (PW + 1 > LEN_W) ? PW + 1 : LEN_W;
  localparam int unsigned SUM_W   = SAMPLE_BITS + LEN_W;
  localparam int unsigned STEP_W  = $clog2(SUM_W + 1);

  localparam logic [LEN_W-1:0]  LEN_CAP_L  = LEN_W'(LEN_CAP);
  localparam logic [PW-1:0]     LAST_ADDR  = PW'(MAX_WINDOW - 1);
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(SUM_W - 1);

  wma_state_e state_q, state_d;

  logic [LEN_W-1:0]              win_len_q, win_len_d;
  logic                          mean_mode_q, mean_mode_d;
  logic [PW-1:0]                 pos_q, pos_d;
  logic [PW-1:0]                 clr_q, clr_d;
  logic signed [SAMPLE_BITS-1:0] held_q, held_d;
  logic [LEN_W-1:0]              cnt_q, cnt_d;
  logic                          rd_vld_q, rd_vld_d;
  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic [SUM_W-1:0]              dvd_q, dvd_d;
  logic [LEN_W-1:0]              rem_q, rem_d;
  logic [STEP_W-1:0]             step_q, step_d;
  logic                          div_pos_q, div_pos_d;
  logic                          neg_q, neg_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] out_data_q, out_data_d;

  logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
  logic                   mem_we;
  logic [PW-1:0]          mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic [PW-1:0]          rd_addr;
  logic signed [SAMPLE_BITS-1:0] rd_data_q;

  logic [LEN_W-1:0]       eff_len;
  logic [PW:0]            pos_inc;
  logic [CMP_W-1:0]       pos_cmp, len_cmp;
  logic                   issue;
  logic [SUM_W-1:0]       sum_mag;
  logic [LEN_W:0]         r_shift, r_sub;
  logic                   r_ge;
  logic [SAMPLE_BITS-1:0] quo;

  // window length: zero counts as one, saturated at the ring depth or at the LEN_W-bit maximum, whichever is lower
  always_comb begin
    if (win_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (win_len_q > LEN_CAP_L) begin
      eff_len = LEN_CAP_L;
    end else begin
      eff_len = win_len_q;
    end
  end

  assign pos_inc = {1'b0, pos_q} + (PW + 1)'(1);
  assign pos_cmp = CMP_W'(pos_inc);
  assign len_cmp = CMP_W'(eff_len);
  assign issue   = (cnt_q != eff_len);

  // restoring divider step
  assign r_shift = {rem_q, dvd_q[SUM_W-1]};
  assign r_ge    = (r_shift >= {1'b0, eff_len});
  assign r_sub   = r_shift - {1'b0, eff_len};

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign mean_value_o = out_data_q;

  always_comb begin
    win_len_d   = win_len_q;
    mean_mode_d = mean_mode_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_LENGTH: win_len_d   = cfg_data_i;
        CFG_MEAN_MODE:     mean_mode_d = cfg_data_i[0];
        default:           win_len_d   = win_len_q;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    clr_d       = clr_q;
    held_d      = held_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    sum_d       = sum_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    step_d      = step_q;
    div_pos_d   = div_pos_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = sample_i;
    rd_addr     = '0;
    sum_mag     = '0;
    quo         = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + PW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          mem_we = 1'b1;
          cnt_d  = '0;
          sum_d  = '0;
          if (pos_cmp < len_cmp) begin
            pos_d   = pos_inc[PW-1:0];
            state_d = mean_mode_q ? ST_SUM : ST_DONE;
          end else if (pos_cmp == len_cmp) begin
            pos_d   = '0;
            state_d = mean_mode_q ? ST_SUM : ST_DONE;
          end else begin
            // position past a shrunken window: remainder from the divider
            dvd_d     = SUM_W'(pos_inc);
            rem_d     = '0;
            step_d    = '0;
            div_pos_d = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_SUM: begin
        if (issue) begin
          rd_addr = PW'(cnt_q);
          cnt_d   = cnt_q + LEN_W'(1);
        end
        rd_vld_d = issue;
        if (rd_vld_q) begin
          sum_d = sum_q + SUM_W'(rd_data_q);
        end
        if (!issue && rd_vld_q) begin
          sum_mag   = sum_d[SUM_W-1] ? (~sum_d + SUM_W'(1)) : sum_d;
          dvd_d     = sum_mag;
          neg_d     = sum_d[SUM_W-1];
          rem_d     = '0;
          step_d    = '0;
          div_pos_d = 1'b0;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = r_ge ? r_sub[LEN_W-1:0] : r_shift[LEN_W-1:0];
        dvd_d  = {dvd_q[SUM_W-2:0], r_ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          if (div_pos_q) begin
            pos_d   = PW'(rem_d);
            cnt_d   = '0;
            sum_d   = '0;
            state_d = mean_mode_q ? ST_SUM : ST_DONE;
          end else begin
            quo     = dvd_d[SAMPLE_BITS-1:0];
            held_d  = neg_q ? -quo : quo;
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = held_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      win_len_q   <= LEN_W'(1);
      mean_mode_q <= 1'b1;
      pos_q       <= '0;
      clr_q       <= '0;
      held_q      <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      step_q      <= '0;
      div_pos_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_len_q   <= win_len_d;
      mean_mode_q <= mean_mode_d;
      pos_q       <= pos_d;
      clr_q       <= clr_d;
      held_q      <= held_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      step_q      <= step_d;
      div_pos_q   <= div_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
  end

  // sample ring
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= ring_mem[rd_addr];
  end

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in progress");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && (step_q != '0) |-> rem_q < eff_len)
    else $error("divider remainder not below window length");

  a_read_only_in_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_SUM) && (cnt_q != '0))
    else $error("ring read data outside window sum");

endmodule

[tb/tb_windowed_moving_average.sv]
module tb_windowed_moving_average;
  timeunit 1ns;
  timeprecision 1ps;

  import wma_pkg::*;

  localparam int unsigned RING_DEPTH    = 64;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS   = 100;
  localparam int unsigned STALL_CYCLES  = 400;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned TAIL_CYCLES   = 200;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e                   kind;
    cfg_reg_e                    reg_sel;
    logic [LEN_W-1:0]            reg_value;
    logic signed [SAMPLE_W-1:0]  sample;
    bit                          typed;
    logic signed [SAMPLE_W-1:0]  mean;
  } stim_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  cfg_reg_e                    cfg_index_i;
  logic [LEN_W-1:0]            cfg_data_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic signed [SAMPLE_W-1:0]  sample_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic signed [SAMPLE_W-1:0]  mean_value_o;

  // predictor state
  logic signed [SAMPLE_W-1:0]  ring_q [RING_DEPTH];
  int unsigned                 wr_pos;
  logic signed [SAMPLE_W-1:0]  held_mean;
  logic [LEN_W-1:0]            win_len;
  logic                        mean_on;

  logic signed [SAMPLE_W-1:0]  pending_means [$];
  stim_row_t                   directed_rows [$];
  int unsigned                 fault_count = 0;
  int unsigned                 idle_cycles = 0;
  bit                          tx_gaps = 1'b1;
  bit                          rx_gaps = 1'b1;
  bit                          stall_req = 1'b0;

  windowed_moving_average #(
    .MAX_WINDOW  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mean_value_o (mean_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] window_mean_after(
    input logic signed [SAMPLE_W-1:0] s
  );
    int unsigned len;
    int unsigned pos;
    int unsigned k;
    longint      acc;
    if (win_len == 0) len = 1;
    else if (win_len > RING_DEPTH) len = RING_DEPTH;
    else len = win_len;
    pos = wr_pos % RING_DEPTH;
    ring_q[pos] = s;
    wr_pos = (pos + 1) % len;
    if (mean_on) begin
      acc = 0;
      for (k = 0; k < len; k++) acc += ring_q[k];
      held_mean = SAMPLE_W'(acc / longint'(len));
    end
    return held_mean;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fault_count++;
  endtask

  task automatic check_mean(input logic signed [SAMPLE_W-1:0] got);
    logic signed [SAMPLE_W-1:0] want;
    if (pending_means.size() == 0) begin
      report_mismatch($sformatf("mean_value %0d with no transfer pending", got));
    end else begin
      want = pending_means.pop_front();
      if (got !== want)
        report_mismatch($sformatf("mean_value got %0d want %0d", got, want));
    end
  endtask

  task automatic send_sample(
    input logic signed [SAMPLE_W-1:0] s,
    input bit                         typed,
    input logic signed [SAMPLE_W-1:0] typed_mean
  );
    int unsigned                gap;
    logic signed [SAMPLE_W-1:0] predicted;
    gap = tx_gaps ? $urandom_range(0, 19) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = window_mean_after(s);
    pending_means.push_back(typed ? typed_mean : predicted);
  endtask

  // stop offering and wait for every pending result
  task automatic settle();
    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e sel, input logic [LEN_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (sel == CFG_WINDOW_LENGTH) win_len = v;
    else mean_on = v[0];
  endtask

  task automatic cfg_release();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned hold;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      hold = rx_gaps ? $urandom_range(0, 19) : 0;
      if (stall_req) begin
        hold += STALL_CYCLES;
        stall_req = 1'b0;
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_mean(mean_value_o);
    end
  end

  initial begin
    logic [LEN_W-1:0]           win;
    logic                       mode;
    logic signed [SAMPLE_W-1:0] s;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_WINDOW_LENGTH;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    foreach (ring_q[i]) ring_q[i] = '0;
    wr_pos    = 0;
    held_mean = '0;
    win_len   = 7'd1;
    mean_on   = 1'b1;

    // after reset the window is one sample, so the mean is the sample itself
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, 16'sh7fff, 1'b1, 16'sh7fff});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, 16'sh8000, 1'b1, 16'sh8000});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, 16'sd0, 1'b1, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, -16'sd1, 1'b1, -16'sd1});
    // zero window acts as one
    directed_rows.push_back('{ROW_CFG, CFG_WINDOW_LENGTH, 7'd0, 16'sd0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, 16'sd1234, 1'b1, 16'sd1234});
    // full-width sum and truncation toward zero
    directed_rows.push_back('{ROW_CFG, CFG_WINDOW_LENGTH, 7'd2, 16'sd0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, 16'sh7fff, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, 16'sh7fff, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, 16'sh8000, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, 16'sh8000, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, -16'sd3, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, 16'sd0, 1'b0, 16'sd0});
    // window beyond the ring saturates
    directed_rows.push_back('{ROW_CFG, CFG_WINDOW_LENGTH, 7'd127, 16'sd0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, 16'sd100, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, -16'sd7000, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, 16'sh7fff, 1'b0, 16'sd0});
    // mean held while only storing
    directed_rows.push_back('{ROW_CFG, CFG_MEAN_MODE, 7'd0, 16'sd0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, 16'sd5, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, -16'sd7, 1'b0, 16'sd0});
    // shrink the window below the write position
    directed_rows.push_back('{ROW_CFG, CFG_WINDOW_LENGTH, 7'd3, 16'sd0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_CFG, CFG_MEAN_MODE, 7'd1, 16'sd0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, 16'sd9, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, 16'sd11, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, -16'sd20, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_CFG, CFG_WINDOW_LENGTH, 7'd64, 16'sd0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_ITEM, CFG_WINDOW_LENGTH, 7'd0, 16'sh7fff, 1'b0, 16'sd0});

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        cfg_write(directed_rows[i].reg_sel, directed_rows[i].reg_value);
        if (i + 1 == directed_rows.size() || directed_rows[i+1].kind != ROW_CFG)
          cfg_release();
      end else begin
        send_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].mean);
      end
    end

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0: win = 7'd127;
        1: win = 7'd64;
        2: win = 7'd0;
        3: win = 7'd1;
        default: win = LEN_W'($urandom_range(0, 127));
      endcase
      mode = (p == 6) ? 1'b0 : ($urandom_range(0, 4) != 0);
      cfg_write(CFG_WINDOW_LENGTH, win);
      cfg_write(CFG_MEAN_MODE, {6'd0, mode});
      cfg_release();
      tx_gaps = ($urandom_range(0, 2) != 0);
      rx_gaps = ($urandom_range(0, 2) != 0);
      // long sink stall so the block backs up onto its input
      if (p == 4) stall_req = 1'b1;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          0: s = 16'sh7fff;
          1: s = 16'sh8000;
          2: s = $signed(16'($urandom_range(0, 8))) - 16'sd4;
          default: s = $signed(16'($urandom));
        endcase
        send_sample(s, 1'b0, 16'sd0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
